@@ hw/rtl/atli_pkg.sv @@
package atli_pkg;
    localparam int NUM_POINTS = 32;
    localparam int MAX_NODES  = 256;
    localparam int NW = 8;
    localparam int PW = 5;
    localparam int CW = 9;
    localparam int AW = NW + PW;

    localparam logic [1:0] OP_HDR   = 2'd0;
    localparam logic [1:0] OP_ANGLE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BELOW = 2'd2;
    localparam logic [1:0] ST_PAST  = 2'd3;

    localparam logic signed [18:0] ONE_Q15 = 19'sd32768;

    typedef struct packed {
        logic          we;
        logic [NW-1:0] addr;
        logic [31:0]   energy;
        logic [31:0]   prob;
        logic [31:0]   slope;
    } t_hdr_wr;

    typedef struct packed {
        logic [31:0] energy;
        logic [31:0] prob;
        logic [31:0] slope;
    } t_hdr;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;
endpackage

@@ hw/rtl/atli_hdr_mem.sv @@
module atli_hdr_mem import atli_pkg::*; (
    input  logic          i_clk,
    input  t_hdr_wr       i_wr,
    input  logic [NW-1:0] i_raddr,
    output t_hdr          o_rdata
);
    t_hdr mem [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= '{energy: i_wr.energy, prob: i_wr.prob, slope: i_wr.slope};
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ hw/rtl/atli_angle_mem.sv @@
module atli_angle_mem import atli_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [17:0]  i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [17:0]  o_rdata
);
    logic signed [17:0] mem [MAX_NODES*NUM_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ hw/rtl/atli_div.sv @@
module atli_div import atli_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [16:0] o_quot
);
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [47:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [16:0] r_q;
    logic [32:0] n_rem;
    logic [33:0] diff;

    always_comb begin
        n_rem = {r_rem[31:0], r_num[47]};
        diff  = {1'b0, n_rem} - {2'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= 6'd48;
                r_num <= {i_req.num, 16'd0};
                r_den <= i_req.den;
                r_rem <= '0;
                r_q   <= '0;
            end else if (r_run) begin
                r_num <= {r_num[46:0], 1'b0};
                if (!diff[33]) begin
                    r_rem <= diff[32:0];
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
endmodule

@@ hw/rtl/angular_table_linear_interp.sv @@
// piecewise-linear table interpolation over energy nodes
// requests: start with i_opcode and payload, taken at an edge where busy is low
// node writes (opcode 0, 1) and unused opcode 3 give no result
// query (opcode 2): a linear search steps over the nodes, each step two header
// reads and a compare, until it brackets the energy between nodes k and k+1;
// then a bit-serial divider forms the fraction (skipped, one half used, when
// node k+1 has no greater energy than node k), the probability and slope
// lerps each take a registered multiply and a result register, and 32 results
// follow one at a time, each from two angle memory reads, a registered multiply
// and the output register; error results: empty table, below first node, at or
// past last node in use; busy stays high until the last result shows, so one
// query runs at a time; results are on o_* for one cycle with o_valid high;
// o_last marks the final one; the receiver cannot stall, the block never holds
// a result; i_cfg_we / i_cfg_data set node_count, which the user must write only
// when idle, as the block does not enforce it; reset (i_rst_n low, synchronous)
// clears node_count and the controller; table memories are not cleared and must
// be written before use
module angular_table_linear_interp import atli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CW-1:0]      i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [NW-1:0]      i_node_index,
    input  logic [PW-1:0]      i_point_index,
    input  logic [31:0]        i_energy,
    input  logic signed [31:0] i_prob_in,
    input  logic signed [31:0] i_slope_in,
    input  logic signed [17:0] i_angle_in,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [PW-1:0]      o_point_out,
    output logic signed [17:0] o_angle_out,
    output logic signed [31:0] o_prob_out,
    output logic signed [31:0] o_slope_out,
    output logic               o_out_of_range,
    output logic               o_last
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_LOW   = 4'd3;
    localparam logic [3:0] S_LOWW  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_LP    = 4'd6;
    localparam logic [3:0] S_LS    = 4'd7;
    localparam logic [3:0] S_A0    = 4'd8;
    localparam logic [3:0] S_A1    = 4'd9;
    localparam logic [3:0] S_A2    = 4'd10;
    localparam logic [3:0] S_LPW   = 4'd11;
    localparam logic [3:0] S_LSW   = 4'd12;
    localparam logic [3:0] S_A3    = 4'd13;

    logic [3:0]  r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_ind;
    logic [31:0] r_e;
    t_hdr        r_lo;
    t_hdr        r_hi;
    logic        r_mid;
    logic [16:0] r_t;
    logic [PW-1:0] r_pt;
    logic signed [17:0] r_vl;
    logic signed [17:0] r_vh;
    logic signed [31:0] r_pr;
    logic signed [31:0] r_sl;

    t_hdr_wr     hwr;
    logic [NW-1:0] hraddr;
    t_hdr        hrd;
    logic        awe;
    logic [AW-1:0] araddr;
    logic signed [17:0] ard;
    t_div_req    dreq;
    logic        ddone;
    logic [16:0] dq;

    logic        acc;
    assign busy = (r_state != S_IDLE);
    assign acc  = start && !busy;

    // lerp datapath, one multiply registered
    logic signed [32:0] m_lo, m_hi, m_d;
    logic signed [17:0] m_t;
    logic signed [50:0] r_prod;
    logic signed [32:0] r_mlo;
    logic signed [50:0] sh;
    logic signed [33:0] res;

    always_comb begin
        m_lo = '0;
        m_hi = '0;
        if (r_state == S_LP) begin
            m_lo = {r_lo.prob[31], r_lo.prob};
            m_hi = {r_hi.prob[31], r_hi.prob};
        end else if (r_state == S_LS) begin
            m_lo = {r_lo.slope[31], r_lo.slope};
            m_hi = {r_hi.slope[31], r_hi.slope};
        end else begin
            m_lo = {{15{r_vl[17]}}, r_vl};
            m_hi = {{15{ard[17]}}, ard};
        end
        m_d = m_hi - m_lo;
        m_t = r_mid ? 18'sd32768 : $signed({1'b0, r_t});
        sh  = r_prod >>> 16;
        res = {r_mlo[32], r_mlo} + sh[33:0];
    end

    assign hwr.we     = acc && i_opcode == OP_HDR;
    assign hwr.addr   = i_node_index;
    assign hwr.energy = i_energy;
    assign hwr.prob   = i_prob_in;
    assign hwr.slope  = i_slope_in;
    assign awe        = acc && i_opcode == OP_ANGLE;

    always_comb begin
        hraddr = r_ind[NW-1:0];
        if (r_state == S_SCAN) hraddr = r_ind[NW-1:0] + 8'd1;
        if (r_state == S_A0) araddr = {r_ind[NW-1:0], r_pt};
        else araddr = {r_ind[NW-1:0] + 8'd1, r_pt};
    end

    atli_hdr_mem u_hdr (.i_clk(i_clk), .i_wr(hwr), .i_raddr(hraddr), .o_rdata(hrd));
    atli_angle_mem u_ang (.i_clk(i_clk), .i_we(awe), .i_waddr({i_node_index, i_point_index}),
        .i_wdata(i_angle_in), .i_raddr(araddr), .o_rdata(ard));

    assign dreq.start = (r_state == S_LOWW) && !r_mid;
    assign dreq.num   = r_e - r_lo.energy;
    assign dreq.den   = r_hi.energy - r_lo.energy;
    atli_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_done(ddone), .o_quot(dq));

    function automatic logic bad(input logic signed [18:0] v);
        return (v < -ONE_Q15) || (v > ONE_Q15);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) r_count <= i_cfg_data;
            if (r_state == S_LP || r_state == S_LS || r_state == S_A2) begin
                r_prod <= m_d * m_t;
                r_mlo  <= m_lo;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && i_opcode == OP_QUERY) begin
                        r_e   <= i_energy;
                        r_ind <= '0;
                        r_n   <= (r_count > CW'(MAX_NODES)) ? CW'(MAX_NODES) : r_count;
                        if (r_count == '0) begin
                            o_valid <= 1'b1; o_status <= ST_EMPTY;
                            o_point_out <= '0; o_angle_out <= '0; o_prob_out <= '0;
                            o_slope_out <= '0; o_out_of_range <= 1'b0; o_last <= 1'b1;
                        end else begin
                            r_state <= S_FIRST;
                        end
                    end
                end
                S_FIRST: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // hrd holds node ind, node ind+1 is being read
                    r_lo    <= hrd;
                    r_state <= S_LOW;
                end
                S_LOW: begin
                    // r_lo = node ind; hrd = node ind+1
                    if (r_ind == '0 && r_e < r_lo.energy) begin
                        o_valid <= 1'b1; o_status <= ST_BELOW;
                        o_point_out <= '0; o_angle_out <= '0; o_prob_out <= '0;
                        o_slope_out <= '0; o_out_of_range <= 1'b0; o_last <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_ind + 9'd1 >= r_n) begin
                        o_valid <= 1'b1; o_status <= ST_PAST;
                        o_point_out <= '0; o_angle_out <= '0; o_prob_out <= '0;
                        o_slope_out <= '0; o_out_of_range <= 1'b0; o_last <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (hrd.energy <= r_e) begin
                        r_ind   <= r_ind + 9'd1;
                        r_state <= S_FIRST;
                    end else begin
                        r_hi    <= hrd;
                        r_mid   <= (hrd.energy <= r_lo.energy);
                        r_state <= S_LOWW;
                    end
                end
                S_LOWW: begin
                    r_state <= r_mid ? S_LP : S_DIV;
                    r_t     <= '0;
                end
                S_DIV: begin
                    if (ddone) begin
                        r_t     <= dq;
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    r_state <= S_LPW;
                end
                S_LPW: begin
                    r_pr <= res[31:0]; r_state <= S_LS;
                end
                S_LS: begin
                    r_state <= S_LSW;
                end
                S_LSW: begin
                    r_sl <= res[31:0]; r_pt <= '0; r_state <= S_A0;
                end
                S_A0: begin
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_vl <= ard; r_state <= S_A2;
                end
                S_A2: begin
                    r_vh <= ard; r_state <= S_A3;
                end
                S_A3: begin
                    o_valid <= 1'b1; o_status <= ST_OK;
                    o_point_out <= r_pt;
                    o_angle_out <= res[17:0];
                    o_prob_out <= r_pr; o_slope_out <= r_sl;
                    o_out_of_range <= bad({r_vl[17], r_vl}) || bad({r_vh[17], r_vh}) ||
                        (!r_mid && bad(res[18:0]));
                    o_last <= (r_pt == PW'(NUM_POINTS - 1));
                    r_pt <= r_pt + 5'd1;
                    r_state <= (r_pt == PW'(NUM_POINTS - 1)) ? S_IDLE : S_A0;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ap_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last) else $error("error without last");
    ap_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy) else $error("busy after last");
    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy) else $error("idle mid query");
endmodule
